/* hdl/hgi_pkg.sv */
// Shared types, field layout and hex-grid constants for the height interpolator.
// No dependencies; used by hgi_tri_select and hex_grid_height_interpolator.
package hgi_pkg;

   // Default sizes of the map and of the query fraction.
   localparam int MAP_DIM_DEF       = 512;
   localparam int POS_FRAC_BITS_DEF = 8;

   // Fixed field widths.
   localparam int POS_W   = 20;
   localparam int COORD_W = 9;
   localparam int HGT_W   = 8;
   localparam int CSR_W   = 10;
   localparam int VAL_W   = 18;

   // Request word layout, lowest bit first.
   localparam int POSX_LSB    = 0;
   localparam int POSY_LSB    = POSX_LSB + POS_W;
   localparam int COL_LSB     = POSY_LSB + POS_W;
   localparam int ROW_LSB     = COL_LSB + COORD_W;
   localparam int HGT_LSB     = ROW_LSB + COORD_W;
   localparam int REQ_USED_W  = HGT_LSB + HGT_W;
   localparam int REQ_TDATA_W = ((REQ_USED_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((VAL_W + 7) / 8) * 8;

   // Item kinds carried on tuser.
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // Register indexes and reset value.
   localparam logic              CSR_MAP_WIDTH  = 1'b0;
   localparam logic              CSR_MAP_HEIGHT = 1'b1;
   localparam logic [CSR_W-1:0]  CSR_DIM_RESET  = 10'd512;

   // Hex neighborhood: six triangles around the center texel.
   localparam int NUM_TRI = 6;

   typedef logic signed [2:0] coef_type;
   typedef logic signed [1:0] off_type;

   // Doubled geometric corner offsets of the hex.
   localparam coef_type GEO_X [NUM_TRI] = '{3'sd1, 3'sd2, 3'sd1, -3'sd1, -3'sd2, -3'sd1};
   localparam coef_type GEO_Y [NUM_TRI] = '{3'sd2, 3'sd0, -3'sd2, -3'sd2, 3'sd0, 3'sd2};

   // Texel offsets of the matching neighbors.
   localparam off_type TEX_X [NUM_TRI] = '{2'sd0, 2'sd1, 2'sd0, -2'sd1, -2'sd1, -2'sd1};
   localparam off_type TEX_Y [NUM_TRI] = '{2'sd1, 2'sd0, -2'sd1, -2'sd1, 2'sd0, 2'sd1};

   // Texel offsets of the two outer corners of the chosen triangle.
   typedef struct packed {
      off_type ax;
      off_type ay;
      off_type bx;
      off_type by;
   } tex_off_type;

   // Triangle that follows a given one around the hex.
   function automatic int next_corner(input int i);
      return (i == NUM_TRI - 1) ? 0 : i + 1;
   endfunction

endpackage

/* hdl/hgi_tri_select.sv */
// Barycentric weights for the six hex triangles and first-fit selection.
// Depends on hgi_pkg for the corner tables and the offset struct.
module hgi_tri_select #(
   parameter int POS_FRAC_BITS = hgi_pkg::POS_FRAC_BITS_DEF
) (
   input  logic signed [POS_FRAC_BITS+1:0] off_x,
   input  logic signed [POS_FRAC_BITS+1:0] off_y,
   output logic [POS_FRAC_BITS+2:0]        wgt_a,
   output logic [POS_FRAC_BITS+2:0]        wgt_b,
   output logic [POS_FRAC_BITS+2:0]        wgt_c,
   output hgi_pkg::tex_off_type            tex_off
);

   localparam int WW = POS_FRAC_BITS + 6;
   localparam int PW = POS_FRAC_BITS + 2;
   localparam logic signed [WW-1:0] FULL = WW'(1 << (POS_FRAC_BITS + 2));

   logic signed [WW-1:0]          ox;
   logic signed [WW-1:0]          oy;
   logic signed [WW-1:0]          wa [hgi_pkg::NUM_TRI];
   logic signed [WW-1:0]          wb [hgi_pkg::NUM_TRI];
   logic signed [WW-1:0]          wc [hgi_pkg::NUM_TRI];
   logic [hgi_pkg::NUM_TRI-1:0]   fit;

   assign ox = WW'(off_x);
   assign oy = WW'(off_y);

   // Weights of all six triangles in parallel; each has denominator -4.
   always_comb begin
      for (int i = 0; i < hgi_pkg::NUM_TRI; i++) begin
         wa[i] = WW'(hgi_pkg::GEO_X[hgi_pkg::next_corner(i)] * oy)
               - WW'(hgi_pkg::GEO_Y[hgi_pkg::next_corner(i)] * ox);
         wb[i] = WW'(hgi_pkg::GEO_Y[i] * ox) - WW'(hgi_pkg::GEO_X[i] * oy);
         wc[i] = FULL - wa[i] - wb[i];
         fit[i] = !wa[i][WW-1] && !wb[i][WW-1] && !wc[i][WW-1];
      end
   end

   // First fitting triangle wins. With no fit the center takes the full weight
   // and both corners point at the center texel.
   always_comb begin
      wgt_a   = '0;
      wgt_b   = '0;
      wgt_c   = FULL[PW:0];
      tex_off = '0;
      for (int i = hgi_pkg::NUM_TRI - 1; i >= 0; i--) begin
         if (fit[i]) begin
            wgt_a      = wa[i][PW:0];
            wgt_b      = wb[i][PW:0];
            wgt_c      = wc[i][PW:0];
            tex_off.ax = hgi_pkg::TEX_X[i];
            tex_off.ay = hgi_pkg::TEX_Y[i];
            tex_off.bx = hgi_pkg::TEX_X[hgi_pkg::next_corner(i)];
            tex_off.by = hgi_pkg::TEX_Y[hgi_pkg::next_corner(i)];
         end
      end
   end

endmodule

/* hdl/hgi_texel_ram.sv */
// Height map storage: three identical copies, one write port shared by all,
// one registered read port per copy. No dependencies.
module hgi_texel_ram #(
   parameter int ADDR_W = 18,
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   input  logic [ADDR_W-1:0] rd_addr_c,
   output logic [DATA_W-1:0] rd_data_a,
   output logic [DATA_W-1:0] rd_data_b,
   output logic [DATA_W-1:0] rd_data_c,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] mem_a_ff [DEPTH];
   logic [DATA_W-1:0] mem_b_ff [DEPTH];
   logic [DATA_W-1:0] mem_c_ff [DEPTH];
   logic [DATA_W-1:0] rdata_a_ff;
   logic [DATA_W-1:0] rdata_b_ff;
   logic [DATA_W-1:0] rdata_c_ff;

   // Every write goes to all three copies so each read port sees the same map.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_a_ff[wr_addr] <= wr_data;
         mem_b_ff[wr_addr] <= wr_data;
         mem_c_ff[wr_addr] <= wr_data;
      end
   end

   // Read data holds while the stage is stalled.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_a_ff <= mem_a_ff[rd_addr_a];
         rdata_b_ff <= mem_b_ff[rd_addr_b];
         rdata_c_ff <= mem_c_ff[rd_addr_c];
      end
   end

   assign rd_data_a = rdata_a_ff;
   assign rd_data_b = rdata_b_ff;
   assign rd_data_c = rdata_c_ff;

endmodule

/* hdl/hex_grid_height_interpolator.sv */
// Hex-grid height interpolator: seven-stage pipeline with a three-copy height map.
// Throughput: one word per cycle unless the result channel stalls the pipeline;
// the three map copies give the three texel reads per cycle.
// Reset clears all valid bits and sets map_width and map_height to 512.
// The height map itself is not cleared; a texel reads undefined until written.
// Depends on hgi_pkg, hgi_tri_select and hgi_texel_ram.
module hex_grid_height_interpolator #(
   parameter int MAP_DIM       = hgi_pkg::MAP_DIM_DEF,
   parameter int POS_FRAC_BITS = hgi_pkg::POS_FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata from bit 0: pos_x, pos_y, texel_col, texel_row, texel_height, zero pad
   input  logic [hgi_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // tuser: kind
   input  logic                              req_tuser,
   // Result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata from bit 0: height_value, zero pad
   output logic [hgi_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // Configuration port
   input  logic                              csr_we,
   input  logic                              csr_index,
   input  logic [hgi_pkg::CSR_W-1:0]         csr_wdata
);

   localparam int F     = POS_FRAC_BITS;
   localparam int POS_W = hgi_pkg::POS_W;
   localparam int HGT_W = hgi_pkg::HGT_W;
   localparam int AW    = $clog2(MAP_DIM);
   localparam int DW    = $clog2(MAP_DIM + 1);
   localparam int EW    = ((DW > hgi_pkg::CSR_W) ? DW : hgi_pkg::CSR_W) + 1;
   localparam int CAW   = ((AW > hgi_pkg::COORD_W) ? AW : hgi_pkg::COORD_W) + 1;
   localparam int CXW   = POS_W + 1 - F;
   localparam int SW    = ((CXW > EW) ? CXW : EW) + 3;
   localparam int PW    = F + 2;
   localparam int WGW   = F + 3;
   localparam int PRW   = WGW + HGT_W;
   localparam int SUMW  = PRW + 2;
   localparam int RSH   = (F > 8) ? F - 8 : 0;
   localparam int LSH   = (F > 8) ? 0 : 8 - F;
   localparam int QW    = SUMW + LSH + 1;
   localparam int RND   = (1 << RSH) >> 1;

   localparam logic signed [POS_W:0]   RND_POS = (POS_W + 1)'(1 << (F - 1));
   localparam logic signed [POS_W:0]   RND_NEG = (POS_W + 1)'((1 << (F - 1)) - 1);
   localparam logic [WGW:0]            WSUM    = (WGW + 1)'(1 << (F + 2));
   localparam logic signed [PW-1:0]    PX_LIM  = PW'(1 << F);

   // ------------------------------------------------------------------
   // Configuration registers and effective map bounds
   // ------------------------------------------------------------------
   logic [hgi_pkg::CSR_W-1:0] map_width_ff;
   logic [hgi_pkg::CSR_W-1:0] map_height_ff;
   logic [EW-1:0]             ext_w;
   logic [EW-1:0]             ext_h;
   logic [EW-1:0]             eff_w;
   logic [EW-1:0]             eff_h;
   logic [EW-1:0]             half_w;
   logic [EW-1:0]             half_h;
   logic [EW-1:0]             max_w;
   logic [EW-1:0]             max_h;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= hgi_pkg::CSR_DIM_RESET;
         map_height_ff <= hgi_pkg::CSR_DIM_RESET;
      end else if (csr_we) begin
         case (csr_index)
            hgi_pkg::CSR_MAP_WIDTH:  map_width_ff  <= csr_wdata;
            hgi_pkg::CSR_MAP_HEIGHT: map_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // A zero dimension counts as one, anything above the map as the map size.
   assign ext_w = EW'(map_width_ff);
   assign ext_h = EW'(map_height_ff);

   always_comb begin
      if (ext_w == '0) begin
         eff_w = EW'(1);
      end else if (ext_w > EW'(MAP_DIM)) begin
         eff_w = EW'(MAP_DIM);
      end else begin
         eff_w = ext_w;
      end
      if (ext_h == '0) begin
         eff_h = EW'(1);
      end else if (ext_h > EW'(MAP_DIM)) begin
         eff_h = EW'(MAP_DIM);
      end else begin
         eff_h = ext_h;
      end
   end

   assign half_w = eff_w >> 1;
   assign half_h = eff_h >> 1;
   assign max_w  = eff_w - EW'(1);
   assign max_h  = eff_h - EW'(1);

   // Clamp a centered texel coordinate into [0, lim_max].
   function automatic logic [AW-1:0] clamp_coord(input logic signed [SW-1:0] c,
                                                  input logic [EW-1:0]        lim_max);
      logic signed [SW-1:0] mx;
      mx = signed'(SW'(lim_max));
      if (c < 0) begin
         return '0;
      end else if (c > mx) begin
         return lim_max[AW-1:0];
      end else begin
         return c[AW-1:0];
      end
   endfunction

   // ------------------------------------------------------------------
   // Stage handshake: a stage loads when it is empty or the next one loads
   // ------------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

   assign rdy7 = !v7_ff || rsp_tready;
   assign rdy6 = !v6_ff || rdy7;
   assign rdy5 = !v5_ff || rdy6;
   assign rdy4 = !v4_ff || rdy5;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign req_tready = rdy1;

   // ------------------------------------------------------------------
   // Stage 1: unpack the request word, round the query point
   // ------------------------------------------------------------------
   logic signed [POS_W-1:0]       req_pos_x;
   logic signed [POS_W-1:0]       req_pos_y;
   logic [hgi_pkg::COORD_W-1:0]   req_col;
   logic [hgi_pkg::COORD_W-1:0]   req_row;
   logic signed [POS_W:0]         sum_x;
   logic signed [POS_W:0]         sum_y;
   logic signed [CXW-1:0]         cx_in;
   logic signed [CXW-1:0]         cy_in;
   logic                          we_in;

   logic                          q1_ff;
   logic                          we1_ff;
   logic signed [POS_W-1:0]       pos_x1_ff;
   logic signed [POS_W-1:0]       pos_y1_ff;
   logic signed [CXW-1:0]         cx1_ff;
   logic signed [CXW-1:0]         cy1_ff;
   logic [AW-1:0]                 wcol1_ff;
   logic [AW-1:0]                 wrow1_ff;
   logic [HGT_W-1:0]              hgt1_ff;

   assign req_pos_x = req_tdata[hgi_pkg::POSX_LSB +: POS_W];
   assign req_pos_y = req_tdata[hgi_pkg::POSY_LSB +: POS_W];
   assign req_col   = req_tdata[hgi_pkg::COL_LSB +: hgi_pkg::COORD_W];
   assign req_row   = req_tdata[hgi_pkg::ROW_LSB +: hgi_pkg::COORD_W];

   // Half away from zero: floor(x + half) above zero, floor(x + half - 1) below.
   assign sum_x = (POS_W + 1)'(req_pos_x) + (req_pos_x[POS_W-1] ? RND_NEG : RND_POS);
   assign sum_y = (POS_W + 1)'(req_pos_y) + (req_pos_y[POS_W-1] ? RND_NEG : RND_POS);
   assign cx_in = CXW'(sum_x >>> F);
   assign cy_in = CXW'(sum_y >>> F);

   // Writes outside the store are dropped.
   assign we_in = (req_tuser == hgi_pkg::KIND_WRITE)
               && (CAW'(req_col) < CAW'(MAP_DIM))
               && (CAW'(req_row) < CAW'(MAP_DIM));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (rdy1) begin
         v1_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         q1_ff     <= (req_tuser == hgi_pkg::KIND_QUERY);
         we1_ff    <= we_in;
         pos_x1_ff <= req_pos_x;
         pos_y1_ff <= req_pos_y;
         cx1_ff    <= cx_in;
         cy1_ff    <= cy_in;
         wcol1_ff  <= AW'(CAW'(req_col));
         wrow1_ff  <= AW'(CAW'(req_row));
         hgt1_ff   <= req_tdata[hgi_pkg::HGT_LSB +: HGT_W];
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: doubled offset of the point from its texel center
   // ------------------------------------------------------------------
   logic signed [POS_W+1:0] dx_full;
   logic signed [POS_W+1:0] dy_full;
   logic signed [PW-1:0]    px_in;
   logic signed [PW-1:0]    py_in;

   logic                    q2_ff;
   logic                    we2_ff;
   logic signed [PW-1:0]    px2_ff;
   logic signed [PW-1:0]    py2_ff;
   logic signed [CXW-1:0]   cx2_ff;
   logic signed [CXW-1:0]   cy2_ff;
   logic [AW-1:0]           wcol2_ff;
   logic [AW-1:0]           wrow2_ff;
   logic [HGT_W-1:0]        hgt2_ff;

   assign dx_full = (POS_W + 2)'(pos_x1_ff) - ((POS_W + 2)'(cx1_ff) <<< F);
   assign dy_full = (POS_W + 2)'(pos_y1_ff) - ((POS_W + 2)'(cy1_ff) <<< F);
   assign px_in   = {dx_full[F:0], 1'b0};
   assign py_in   = {dy_full[F:0], 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (rdy2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         q2_ff    <= q1_ff;
         we2_ff   <= we1_ff;
         px2_ff   <= px_in;
         py2_ff   <= py_in;
         cx2_ff   <= cx1_ff;
         cy2_ff   <= cy1_ff;
         wcol2_ff <= wcol1_ff;
         wrow2_ff <= wrow1_ff;
         hgt2_ff  <= hgt1_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: pick the triangle and its weights
   // ------------------------------------------------------------------
   logic [WGW-1:0]        wa_in;
   logic [WGW-1:0]        wb_in;
   logic [WGW-1:0]        wc_in;
   hgi_pkg::tex_off_type  off_in;

   logic                  q3_ff;
   logic                  we3_ff;
   logic [WGW-1:0]        wa3_ff;
   logic [WGW-1:0]        wb3_ff;
   logic [WGW-1:0]        wc3_ff;
   hgi_pkg::tex_off_type  off3_ff;
   logic signed [CXW-1:0] cx3_ff;
   logic signed [CXW-1:0] cy3_ff;
   logic [AW-1:0]         wcol3_ff;
   logic [AW-1:0]         wrow3_ff;
   logic [HGT_W-1:0]      hgt3_ff;

   hgi_tri_select #(
      .POS_FRAC_BITS (POS_FRAC_BITS)
   ) u_tri_select (
      .off_x   (px2_ff),
      .off_y   (py2_ff),
      .wgt_a   (wa_in),
      .wgt_b   (wb_in),
      .wgt_c   (wc_in),
      .tex_off (off_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (rdy3) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         q3_ff    <= q2_ff;
         we3_ff   <= we2_ff;
         wa3_ff   <= wa_in;
         wb3_ff   <= wb_in;
         wc3_ff   <= wc_in;
         off3_ff  <= off_in;
         cx3_ff   <= cx2_ff;
         cy3_ff   <= cy2_ff;
         wcol3_ff <= wcol2_ff;
         wrow3_ff <= wrow2_ff;
         hgt3_ff  <= hgt2_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: clamped map addresses of the three corner texels
   // ------------------------------------------------------------------
   logic signed [SW-1:0] ta_x, ta_y, tb_x, tb_y, tc_x, tc_y;
   logic [2*AW-1:0]      ra_in;
   logic [2*AW-1:0]      rb_in;
   logic [2*AW-1:0]      rc_in;

   logic                 q4_ff;
   logic                 we4_ff;
   logic [WGW-1:0]       wa4_ff;
   logic [WGW-1:0]       wb4_ff;
   logic [WGW-1:0]       wc4_ff;
   logic [2*AW-1:0]      ra4_ff;
   logic [2*AW-1:0]      rb4_ff;
   logic [2*AW-1:0]      rc4_ff;
   logic [2*AW-1:0]      waddr4_ff;
   logic [HGT_W-1:0]     hgt4_ff;

   assign tc_x = SW'(cx3_ff) + signed'(SW'(half_w));
   assign tc_y = SW'(cy3_ff) + signed'(SW'(half_h));
   assign ta_x = tc_x + SW'(off3_ff.ax);
   assign ta_y = tc_y + SW'(off3_ff.ay);
   assign tb_x = tc_x + SW'(off3_ff.bx);
   assign tb_y = tc_y + SW'(off3_ff.by);

   // Map address is {row, col}.
   assign ra_in = {clamp_coord(ta_y, max_h), clamp_coord(ta_x, max_w)};
   assign rb_in = {clamp_coord(tb_y, max_h), clamp_coord(tb_x, max_w)};
   assign rc_in = {clamp_coord(tc_y, max_h), clamp_coord(tc_x, max_w)};

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (rdy4) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         q4_ff     <= q3_ff;
         we4_ff    <= we3_ff;
         wa4_ff    <= wa3_ff;
         wb4_ff    <= wb3_ff;
         wc4_ff    <= wc3_ff;
         ra4_ff    <= ra_in;
         rb4_ff    <= rb_in;
         rc4_ff    <= rc_in;
         waddr4_ff <= {wrow3_ff, wcol3_ff};
         hgt4_ff   <= hgt3_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: map access. Writes and reads both happen as a word leaves
   // stage 4, so every query sees exactly the writes taken before it.
   // ------------------------------------------------------------------
   logic             ram_we;
   logic [HGT_W-1:0] ha;
   logic [HGT_W-1:0] hb;
   logic [HGT_W-1:0] hc;

   logic             q5_ff;
   logic [WGW-1:0]   wa5_ff;
   logic [WGW-1:0]   wb5_ff;
   logic [WGW-1:0]   wc5_ff;

   assign ram_we = rdy5 && v4_ff && we4_ff;

   hgi_texel_ram #(
      .ADDR_W (2 * AW),
      .DATA_W (HGT_W)
   ) u_texel_ram (
      .clock     (clock),
      .rd_en     (rdy5),
      .rd_addr_a (ra4_ff),
      .rd_addr_b (rb4_ff),
      .rd_addr_c (rc4_ff),
      .rd_data_a (ha),
      .rd_data_b (hb),
      .rd_data_c (hc),
      .wr_en     (ram_we),
      .wr_addr   (waddr4_ff),
      .wr_data   (hgt4_ff)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (rdy5) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy5) begin
         q5_ff  <= q4_ff;
         wa5_ff <= wa4_ff;
         wb5_ff <= wb4_ff;
         wc5_ff <= wc4_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 6: weighted heights; write words end here
   // ------------------------------------------------------------------
   logic [PRW-1:0] pa6_ff;
   logic [PRW-1:0] pb6_ff;
   logic [PRW-1:0] pc6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (rdy6) begin
         v6_ff <= v5_ff && q5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy6) begin
         pa6_ff <= PRW'(wa5_ff) * PRW'(ha);
         pb6_ff <= PRW'(wb5_ff) * PRW'(hb);
         pc6_ff <= PRW'(wc5_ff) * PRW'(hc);
      end
   end

   // ------------------------------------------------------------------
   // Stage 7: sum and rescale to 10 fraction bits; output register
   // ------------------------------------------------------------------
   logic [SUMW-1:0]           sum_in;
   logic [QW-1:0]             q10_in;
   logic [hgi_pkg::VAL_W-1:0] res7_ff;

   assign sum_in = SUMW'(pa6_ff) + SUMW'(pb6_ff) + SUMW'(pc6_ff) + SUMW'(RND);
   assign q10_in = (QW'(sum_in) >> RSH) << LSH;

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (rdy7) begin
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy7) begin
         res7_ff <= q10_in[hgi_pkg::VAL_W-1:0];
      end
   end

   assign rsp_tvalid = v7_ff;
   assign rsp_tdata  = hgi_pkg::RSP_TDATA_W'(res7_ff);

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------

   // Rounding leaves the doubled offset within one texel of the center.
   assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> (px2_ff <= PX_LIM) && (px2_ff >= -PX_LIM) &&
                (py2_ff <= PX_LIM) && (py2_ff >= -PX_LIM))
      else $error("query offset outside one texel");

   // The chosen weights always add up to the full scale.
   assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> ((WGW + 1)'(wa3_ff) + (WGW + 1)'(wb3_ff) + (WGW + 1)'(wc3_ff)) == WSUM)
      else $error("triangle weights do not sum to full scale");

   // Clamped center address stays inside the configured map.
   assert property (@(posedge clock) disable iff (reset)
      (v4_ff && q4_ff) |-> (EW'(rc4_ff[AW-1:0]) < eff_w) && (EW'(rc4_ff[2*AW-1:AW]) < eff_h))
      else $error("center texel address outside the map");

   // Only query words ever reach the last two stages.
   assert property (@(posedge clock) disable iff (reset)
      (rdy6 && v5_ff && !q5_ff) |=> !v6_ff)
      else $error("write word passed the map stage");

endmodule
